FILE: hdl/assert_macros.svh
// Assertion macros for the RTL; rvfd_decode includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: hdl/rvfd_pkg.sv
// Types and constants of the run-length varint frame decoder.
package rvfd_pkg;

    localparam int unsigned COLOR_W = 8;
    localparam int unsigned LENGTH_W = 32;
    localparam int unsigned PIXEL_W = 24;
    localparam int unsigned SHIFT_W = 6;

    localparam logic [6:0] VARINT_DATA_MASK = 7'h7F;
    localparam int unsigned CONT_BIT = 7;
    localparam logic [SHIFT_W-1:0] DATA_BITS = 6'd7;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = 6'd35;
    localparam logic [PIXEL_W-1:0] FRAME_LENGTH_RESET = 24'd64000;

    typedef struct packed {
        logic [COLOR_W-1:0]  color;
        logic [LENGTH_W-1:0] length;
        logic [PIXEL_W-1:0]  start_pixel;
        logic                frame_end;
    } run_t;

endpackage

FILE: hdl/rle_varint_frame_decoder.sv
// A run's last byte is held in the input register, then the run is registered for m_valid.
// Throughput: one byte per cycle; the input register advances whenever the result register
// is empty, is being taken, or the byte gives no run.
// Reset: synchronous, active low; decoder waits for a colour byte, pixel count is zero,
// frame_length returns to 64000, both registers empty.
module rle_varint_frame_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rvfd_pkg::PIXEL_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rvfd_pkg::COLOR_W-1:0]  m_run_color,
    output logic [rvfd_pkg::LENGTH_W-1:0] m_run_length,
    output logic [rvfd_pkg::PIXEL_W-1:0]  m_start_pixel,
    output logic                          m_frame_end
);

    logic [rvfd_pkg::PIXEL_W-1:0] frame_length_reg;
    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_data_reg;
    logic                         out_valid_reg, out_valid_next;
    rvfd_pkg::run_t               out_run_reg;

    logic                         adv;
    logic                         emit;
    rvfd_pkg::run_t               run;

    rvfd_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (adv),
        .data_byte    (in_data_reg),
        .frame_length (frame_length_reg),
        .emit         (emit),
        .run          (run)
    );

    always_comb begin
        adv     = in_valid_reg && (!out_valid_reg || m_ready || !emit);
        s_ready = !in_valid_reg || adv;

        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (adv && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg <= rvfd_pkg::FRAME_LENGTH_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                frame_length_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data_byte;
        end
        if (adv && emit) begin
            out_run_reg <= run;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_run_color   = out_run_reg.color;
    assign m_run_length  = out_run_reg.length;
    assign m_start_pixel = out_run_reg.start_pixel;
    assign m_frame_end   = out_run_reg.frame_end;

endmodule

FILE: hdl/rvfd_decode.sv
// Varint length gathering, run assembly and frame pixel counting.
`include "assert_macros.svh"

module rvfd_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [7:0]                    data_byte,
    input  logic [rvfd_pkg::PIXEL_W-1:0]  frame_length,
    output logic                          emit,
    output rvfd_pkg::run_t                run
);

    logic                            expect_color_reg, expect_color_next;
    logic [rvfd_pkg::COLOR_W-1:0]    held_color_reg, held_color_next;
    logic [rvfd_pkg::LENGTH_W-1:0]   length_accum_reg, length_accum_next;
    logic [rvfd_pkg::SHIFT_W-1:0]    bit_shift_reg, bit_shift_next;
    logic [rvfd_pkg::PIXEL_W-1:0]    pixel_count_reg, pixel_count_next;

    logic [rvfd_pkg::LENGTH_W-1:0]   part;
    logic [rvfd_pkg::LENGTH_W-1:0]   accum_upd;
    logic [rvfd_pkg::SHIFT_W-1:0]    shift_upd;
    logic [rvfd_pkg::LENGTH_W:0]     sum;
    logic                            last;

    always_comb begin
        part = {{(rvfd_pkg::LENGTH_W-7){1'b0}}, data_byte[6:0] & rvfd_pkg::VARINT_DATA_MASK}
               << bit_shift_reg[4:0];
        accum_upd = bit_shift_reg[5] ? length_accum_reg : (length_accum_reg | part);
        shift_upd = (bit_shift_reg < rvfd_pkg::SHIFT_LIMIT) ?
                    bit_shift_reg + rvfd_pkg::DATA_BITS : bit_shift_reg;
        sum  = {{(rvfd_pkg::LENGTH_W-rvfd_pkg::PIXEL_W+1){1'b0}}, pixel_count_reg}
               + {1'b0, accum_upd};
        last = sum >= {{(rvfd_pkg::LENGTH_W-rvfd_pkg::PIXEL_W+1){1'b0}}, frame_length};
        emit = !expect_color_reg && !data_byte[rvfd_pkg::CONT_BIT];

        run.color       = held_color_reg;
        run.length      = accum_upd;
        run.start_pixel = pixel_count_reg;
        run.frame_end   = last;

        expect_color_next = expect_color_reg;
        held_color_next   = held_color_reg;
        length_accum_next = length_accum_reg;
        bit_shift_next    = bit_shift_reg;
        pixel_count_next  = pixel_count_reg;

        if (step) begin
            if (expect_color_reg) begin
                held_color_next   = data_byte;
                length_accum_next = '0;
                bit_shift_next    = '0;
                expect_color_next = 1'b0;
            end else if (data_byte[rvfd_pkg::CONT_BIT]) begin
                length_accum_next = accum_upd;
                bit_shift_next    = shift_upd;
            end else begin
                expect_color_next = 1'b1;
                length_accum_next = '0;
                bit_shift_next    = '0;
                pixel_count_next  = last ? '0 : sum[rvfd_pkg::PIXEL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_color_reg <= 1'b1;
            held_color_reg   <= '0;
            length_accum_reg <= '0;
            bit_shift_reg    <= '0;
            pixel_count_reg  <= '0;
        end else begin
            expect_color_reg <= expect_color_next;
            held_color_reg   <= held_color_next;
            length_accum_reg <= length_accum_next;
            bit_shift_reg    <= bit_shift_next;
            pixel_count_reg  <= pixel_count_next;
        end
    end

    `ASSERT_CLK(a_color_then_varint, step && expect_color_reg |=> !expect_color_reg && bit_shift_reg == '0, "colour byte did not open a varint")
    `ASSERT_CLK(a_run_closes_varint, step && emit |=> expect_color_reg && length_accum_reg == '0, "run emitted without closing the varint")
    `ASSERT_CLK(a_shift_bounded, bit_shift_reg <= rvfd_pkg::SHIFT_LIMIT, "varint shift beyond limit")

endmodule

FILE: dv/tb_rle_varint_frame_decoder.sv
// Testbench for the run-length varint frame decoder: directed and random byte streams checked against a run predictor.
module tb_rle_varint_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    class run_scoreboard;
        logic [rvfd_pkg::PIXEL_W-1:0]  frame_len;
        bit                            want_color;
        logic [rvfd_pkg::COLOR_W-1:0]  color;
        logic [rvfd_pkg::LENGTH_W-1:0] accum;
        logic [rvfd_pkg::SHIFT_W-1:0]  shift;
        logic [rvfd_pkg::PIXEL_W-1:0]  count;
        rvfd_pkg::run_t                runs_due[$];
        int                            errors;

        function new();
            frame_len  = rvfd_pkg::FRAME_LENGTH_RESET;
            want_color = 1'b1;
            color      = '0;
            accum      = '0;
            shift      = '0;
            count      = '0;
            errors     = 0;
        endfunction

        function void set_frame_length(logic [rvfd_pkg::PIXEL_W-1:0] v);
            frame_len = v;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [38:0]    part;
            logic [32:0]    sum;
            rvfd_pkg::run_t r;
            if (want_color) begin
                color      = b;
                accum      = '0;
                shift      = '0;
                want_color = 1'b0;
                return;
            end
            if (shift < 32) begin
                part  = {32'b0, b[6:0] & rvfd_pkg::VARINT_DATA_MASK} << shift;
                accum = accum | part[31:0];
            end
            if (shift < rvfd_pkg::SHIFT_LIMIT)
                shift = shift + rvfd_pkg::DATA_BITS;
            if (b[rvfd_pkg::CONT_BIT])
                return;
            sum           = {9'b0, count} + {1'b0, accum};
            r.color       = color;
            r.length      = accum;
            r.start_pixel = count;
            r.frame_end   = (sum >= {9'b0, frame_len});
            runs_due.push_back(r);
            count      = r.frame_end ? '0 : sum[rvfd_pkg::PIXEL_W-1:0];
            want_color = 1'b1;
            accum      = '0;
            shift      = '0;
        endfunction

        function void check_run(logic [rvfd_pkg::COLOR_W-1:0] c,
                                logic [rvfd_pkg::LENGTH_W-1:0] l,
                                logic [rvfd_pkg::PIXEL_W-1:0] p, logic f);
            rvfd_pkg::run_t e;
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run color=%0h length=%0d start=%0d end=%0b",
                         $time, c, l, p, f);
                errors++;
                return;
            end
            e = runs_due.pop_front();
            if (c !== e.color) begin
                $display("%0t: run_color expected %0h got %0h", $time, e.color, c);
                errors++;
            end
            if (l !== e.length) begin
                $display("%0t: run_length expected %0d got %0d", $time, e.length, l);
                errors++;
            end
            if (p !== e.start_pixel) begin
                $display("%0t: start_pixel expected %0d got %0d", $time, e.start_pixel, p);
                errors++;
            end
            if (f !== e.frame_end) begin
                $display("%0t: frame_end expected %0b got %0b", $time, e.frame_end, f);
                errors++;
            end
        endfunction

        function void report_leftover();
            if (runs_due.size() != 0) begin
                $display("%0t: %0d runs never arrived", $time, runs_due.size());
                errors += runs_due.size();
            end
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_we;
    logic [rvfd_pkg::PIXEL_W-1:0]  cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_data_byte;
    logic                          m_valid;
    logic                          m_ready;
    logic [rvfd_pkg::COLOR_W-1:0]  m_run_color;
    logic [rvfd_pkg::LENGTH_W-1:0] m_run_length;
    logic [rvfd_pkg::PIXEL_W-1:0]  m_start_pixel;
    logic                          m_frame_end;

    run_scoreboard sb = new();
    logic [7:0]    stream_q[$];
    bit            quiet = 1'b0;
    int            hold_left = 0;

    rle_varint_frame_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_run_color   (m_run_color),
        .m_run_length  (m_run_length),
        .m_start_pixel (m_start_pixel),
        .m_frame_end   (m_frame_end)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // spells of back-to-back traffic on both sides
    always begin
        repeat ($urandom_range(100, 400)) @(posedge aclk);
        quiet <= ~quiet;
    end

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 30) begin
            m_ready   <= 1'b0;
            hold_left <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_run(m_run_color, m_run_length, m_start_pixel, m_frame_end);
    end

    task automatic queue_random_run(logic [rvfd_pkg::PIXEL_W-1:0] fl);
        logic [31:0] v;
        logic [7:0]  b;
        int          mode;
        int          pad;
        int          n;
        stream_q.push_back(8'($urandom_range(0, 255)));
        mode = $urandom_range(0, 99);
        pad  = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0;
        if (mode < 10) begin
            n = $urandom_range(1, 7);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom_range(0, 255));
                b[rvfd_pkg::CONT_BIT] = (i < n - 1);
                stream_q.push_back(b);
            end
            return;
        end
        if (mode < 20)
            v = '0;
        else if (mode < 75)
            v = $urandom_range(1, fl / 8 + 1);
        else if (mode < 90)
            v = $urandom_range(0, fl);
        else
            v = $urandom();
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            b[rvfd_pkg::CONT_BIT] = (v != 0) || (pad > 0);
            stream_q.push_back(b);
        end while (v != 0);
        while (pad > 0) begin
            pad--;
            b = '0;
            b[rvfd_pkg::CONT_BIT] = (pad > 0);
            stream_q.push_back(b);
        end
    endtask

    task automatic send_stream();
        logic [7:0] b;
        int         gap;
        while (stream_q.size() > 0) begin
            b = stream_q.pop_front();
            s_valid     <= 1'b1;
            s_data_byte <= b;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            sb.note_byte(b);
            gap = pick_gap();
            if (gap > 0 || stream_q.size() == 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (sb.runs_due.size() > 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_frame_length(logic [rvfd_pkg::PIXEL_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_frame_length(v);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [rvfd_pkg::PIXEL_W-1:0] lengths[9];
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_data_byte = '0;
        m_ready     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset frame length: empty run, full 7-bit run, saturated overrun,
        // long varint with dropped and ignored data, run that exactly fills the frame
        stream_q = '{8'h00, 8'h00,
                     8'hFF, 8'h7F,
                     8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                     8'h5A, 8'h80, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hFF, 8'h01,
                     8'h33, 8'h80, 8'hF4, 8'h03};
        send_stream();
        drain();

        lengths = '{24'd1, 24'hFFFFFF, 24'd0, 24'($urandom_range(2, 100)),
                    24'($urandom_range(100, 5000)), rvfd_pkg::FRAME_LENGTH_RESET,
                    24'($urandom_range(5000, 1000000)), 24'($urandom_range(1, 24'hFFFFFF)),
                    24'd1};
        foreach (lengths[i]) begin
            write_frame_length(lengths[i]);
            while (stream_q.size() < 200)
                queue_random_run(lengths[i]);
            send_stream();
            drain();
        end

        sb.report_leftover();
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
